### hw/rtl/nsf_pkg.sv
// nsf_pkg: shared types and constants of the neighborhood smoothing filter.
// Used by every module of the filter; depends on nothing.

package nsf_pkg;

   // default geometry limits
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_MAX_ROWS    = 256;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int SIZE_W     = 9;
   localparam int SUM_W      = 5;
   localparam int COUNT_W    = 4;

   localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH      = 9'd256;
   localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT     = 9'd256;
   localparam logic [SUM_W-1:0]   RST_KEEP_SUM_LIMIT   = 5'd3;
   localparam logic [SUM_W-1:0]   RST_FILL_SUM_LIMIT   = 5'd5;
   localparam logic [COUNT_W-1:0] RST_FILL_COUNT_LIMIT = 4'd3;

   // pixel levels
   localparam logic [1:0] PIX_WHITE = 2'd0;
   localparam logic [1:0] PIX_BLACK = 2'd3;

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_KEEP_SUM_LIMIT,
      REG_FILL_SUM_LIMIT,
      REG_FILL_COUNT_LIMIT
   } csr_index_type;

   // result slots of one queue entry, in emission order
   localparam int SLOT_A = 0; // row zero, left border or computed interior pixel
   localparam int SLOT_B = 1; // right border of the row above
   localparam int SLOT_C = 2; // bottom row zero
   localparam int NUM_SLOTS = 3;

   typedef struct packed {
      logic [SIZE_W-1:0] image_width;
      logic [SIZE_W-1:0] image_height;
      logic              restart;
   } size_cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0]   keep_sum_limit;
      logic [SUM_W-1:0]   fill_sum_limit;
      logic [COUNT_W-1:0] fill_count_limit;
   } limit_cfg_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic                 compute;
      logic [7:0]           a_row;
      logic [7:0]           a_column;
      logic [7:0]           row;
      logic [7:0]           column;
      logic [1:0]           center;
      logic [7:0][1:0]      nbrs;
   } entry_type;

endpackage

### hw/rtl/nsf_queue.sv
// nsf_queue: small register queue of classified entries between front and back.
// Depends on nsf_pkg for the entry type and depth.

module nsf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  nsf_pkg::entry_type          push_entry,
   input  logic                        pop,
   output nsf_pkg::entry_type          head,
   output logic [nsf_pkg::QUEUE_PTR_W:0] level
);
   import nsf_pkg::*;

   entry_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign level = count_ff;

endmodule

### hw/rtl/nsf_front.sv
// nsf_front: pixel intake, raster counters, line stores, window and result classification.
// Depends on nsf_pkg; feeds nsf_queue.

module nsf_front #(
   parameter int MAX_COLUMNS = nsf_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = nsf_pkg::DEF_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nsf_pkg::size_cfg_type         size_cfg,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    pixel_value,
   input  logic [nsf_pkg::QUEUE_PTR_W:0] queue_level,
   output logic                          entry_push,
   output nsf_pkg::entry_type            entry
);
   import nsf_pkg::*;

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int ROW_W = $clog2(MAX_ROWS);

   logic                 accept;
   logic [COL_W-1:0]     col_last;
   logic [ROW_W-1:0]     row_last;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;

   // stage one: memory read data and classification of the accepted pixel
   logic                 s1_valid_ff;
   logic [1:0]           s1_pixel_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [NUM_SLOTS-1:0] s1_slots_ff, slots;
   logic                 s1_compute_ff, compute;
   logic [7:0]           s1_a_row_ff, a_row;
   logic [7:0]           s1_a_column_ff, a_column;
   logic [7:0]           s1_row_ff;
   logic [7:0]           s1_column_ff;

   logic [1:0]           older_line_ff [MAX_COLUMNS];
   logic [1:0]           newer_line_ff [MAX_COLUMNS];
   logic [1:0]           top_rd_ff, mid_rd_ff;
   logic [1:0]           tap_ff [6];

   logic                 first_row, below_second, col_zero, col_ge2, row_end, col_end;

   // effective image size, out-of-range values clamp
   always_comb begin
      if (size_cfg.image_width < 9'd3) begin
         col_last = COL_W'(2);
      end else if (32'(size_cfg.image_width) > MAX_COLUMNS) begin
         col_last = COL_W'(MAX_COLUMNS - 1);
      end else begin
         col_last = COL_W'(size_cfg.image_width - 9'd1);
      end
      if (size_cfg.image_height < 9'd3) begin
         row_last = ROW_W'(2);
      end else if (32'(size_cfg.image_height) > MAX_ROWS) begin
         row_last = ROW_W'(MAX_ROWS - 1);
      end else begin
         row_last = ROW_W'(size_cfg.image_height - 9'd1);
      end
   end

   // room for the entry in flight plus one more
   always_comb begin
      if (s1_valid_ff) begin
         full = (queue_level >= (QUEUE_PTR_W+1)'(QUEUE_DEPTH - 1));
      end else begin
         full = (queue_level >= (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
      end
   end

   assign accept = push && !full;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (size_cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // which results this pixel causes
   always_comb begin
      first_row    = (row_ff == '0);
      below_second = !first_row && (row_ff != ROW_W'(1));
      col_zero     = (col_ff == '0);
      col_ge2      = !col_zero && (col_ff != COL_W'(1));
      row_end      = (row_ff == row_last);
      col_end      = (col_ff == col_last);
      compute      = below_second && col_ge2;
      slots[SLOT_A] = first_row || (below_second && (col_zero || col_ge2));
      slots[SLOT_B] = compute && col_end;
      slots[SLOT_C] = row_end;
      a_row        = first_row ? 8'd0 : 8'(row_ff) - 8'd1;
      a_column     = compute ? 8'(col_ff) - 8'd1 : 8'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= pixel_value;
         s1_col_ff      <= col_ff;
         s1_slots_ff    <= slots;
         s1_compute_ff  <= compute;
         s1_a_row_ff    <= a_row;
         s1_a_column_ff <= a_column;
         s1_row_ff      <= 8'(row_ff);
         s1_column_ff   <= 8'(col_ff);
      end
   end

   // line stores: read on accept, written back in the following cycle at the same column
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= older_line_ff[col_ff];
      end
      if (s1_valid_ff) begin
         older_line_ff[s1_col_ff] <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff <= newer_line_ff[col_ff];
      end
      if (s1_valid_ff) begin
         newer_line_ff[s1_col_ff] <= s1_pixel_ff;
      end
   end

   // window: taps 0..2 previous column top/mid/bottom, 3..5 the column before
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         tap_ff[0] <= top_rd_ff;
         tap_ff[1] <= mid_rd_ff;
         tap_ff[2] <= s1_pixel_ff;
         tap_ff[3] <= tap_ff[0];
         tap_ff[4] <= tap_ff[1];
         tap_ff[5] <= tap_ff[2];
      end
   end

   always_comb begin
      entry.slots    = s1_slots_ff;
      entry.compute  = s1_compute_ff;
      entry.a_row    = s1_a_row_ff;
      entry.a_column = s1_a_column_ff;
      entry.row      = s1_row_ff;
      entry.column   = s1_column_ff;
      entry.center   = tap_ff[1];
      entry.nbrs[0]  = tap_ff[3];
      entry.nbrs[1]  = tap_ff[0];
      entry.nbrs[2]  = top_rd_ff;
      entry.nbrs[3]  = tap_ff[4];
      entry.nbrs[4]  = mid_rd_ff;
      entry.nbrs[5]  = tap_ff[5];
      entry.nbrs[6]  = tap_ff[2];
      entry.nbrs[7]  = s1_pixel_ff;
   end

   assign entry_push = s1_valid_ff && (|s1_slots_ff);

endmodule

### hw/rtl/nsf_back.sv
// nsf_back: evaluates the neighborhood rule and issues the results of each entry in order.
// Depends on nsf_pkg; drains nsf_queue into the result register.

module nsf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  nsf_pkg::limit_cfg_type        limit_cfg,
   input  nsf_pkg::entry_type            head,
   input  logic [nsf_pkg::QUEUE_PTR_W:0] queue_level,
   output logic                          queue_pop,
   output logic                          empty,
   input  logic                          pop,
   output logic [7:0]                    rsp_out_row,
   output logic [7:0]                    rsp_out_column,
   output logic [1:0]                    rsp_smoothed_value,
   output logic                          rsp_last_of_input
);
   import nsf_pkg::*;

   entry_type            cur_ff, cur_in;
   logic [NUM_SLOTS-1:0] slots_ff, slots_in, slots_next, slots_after, low_slot;
   logic [SUM_W-1:0]     sum;
   logic [COUNT_W-1:0]   cnt;
   logic                 filled;
   logic                 out_free, take;
   logic                 valid_ff, valid_in;
   logic [7:0]           row_ff, row_in;
   logic [7:0]           column_ff, column_in;
   logic [1:0]           value_ff, value_in;
   logic                 last_ff, last_in;

   always_comb begin
      sum = '0;
      cnt = '0;
      for (int k = 0; k < 8; k++) begin
         sum = sum + SUM_W'(cur_ff.nbrs[k]);
         cnt = cnt + COUNT_W'(cur_ff.nbrs[k] != PIX_WHITE);
      end
      filled = cur_ff.compute && (sum > limit_cfg.keep_sum_limit) &&
               ((cur_ff.center != PIX_WHITE) ||
                ((sum > limit_cfg.fill_sum_limit) && (cnt > limit_cfg.fill_count_limit)));
   end

   always_comb begin
      out_free    = !valid_ff || pop;
      take        = out_free && (|slots_ff);
      low_slot    = slots_ff & (~slots_ff + 1'b1);
      slots_next  = slots_ff & ~low_slot;
      slots_after = take ? slots_next : slots_ff;
      queue_pop   = (slots_after == '0) && (queue_level != '0);
      slots_in    = queue_pop ? head.slots : slots_after;
      cur_in      = queue_pop ? head : cur_ff;

      row_in    = row_ff;
      column_in = column_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      if (take) begin
         last_in = (slots_next == '0);
         priority if (slots_ff[SLOT_A]) begin
            row_in    = cur_ff.a_row;
            column_in = cur_ff.a_column;
            value_in  = filled ? PIX_BLACK : PIX_WHITE;
         end else if (slots_ff[SLOT_B]) begin
            row_in    = cur_ff.a_row;
            column_in = cur_ff.column;
            value_in  = PIX_WHITE;
         end else begin
            row_in    = cur_ff.row;
            column_in = cur_ff.column;
            value_in  = PIX_WHITE;
         end
      end

      if (take) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         slots_ff <= slots_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      row_ff    <= row_in;
      column_ff <= column_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   assign empty              = !valid_ff;
   assign rsp_out_row        = row_ff;
   assign rsp_out_column     = column_ff;
   assign rsp_smoothed_value = value_ff;
   assign rsp_last_of_input  = last_ff;

endmodule

### hw/rtl/neighborhood_smoothing_filter.sv
// neighborhood_smoothing_filter: top level with configuration registers.
// Depends on nsf_pkg, nsf_front, nsf_queue and nsf_back.

// 3x3 smoothing of a 2-bit raster image. Pixels enter in raster order, one per cycle
// while full is low; each result leaves with its row and column, border pixels give 0 and
// interior pixels give 0 or 3 by their own value and the sum and nonzero count of their
// eight neighbors. An interior result appears once the pixel below and to its right has
// entered, so a row's results trail the input by one row. Most pixels cause one result and
// pass at one per cycle while results are popped; the last pixel of a row from row 2 on
// and most pixels of the last row cause two or three, and since the result port delivers
// at most one per cycle the input stalls briefly there. The four entry queue between the
// intake and the result sequencer absorbs these bursts. Writing image_width or image_height
// restarts the image at row 0, column 0; write registers only while no results are pending.
// After the last pixel of an image the next pixel starts a new image.

module neighborhood_smoothing_filter #(
   parameter int MAX_COLUMNS = nsf_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = nsf_pkg::DEF_MAX_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [1:0]                      req_pixel_value,
   output logic                            empty,
   input  logic                            pop,
   output logic [7:0]                      rsp_out_row,
   output logic [7:0]                      rsp_out_column,
   output logic [1:0]                      rsp_smoothed_value,
   output logic                            rsp_last_of_input,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [nsf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [nsf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [nsf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import nsf_pkg::*;

   logic [SIZE_W-1:0]      image_width_ff, image_width_in;
   logic [SIZE_W-1:0]      image_height_ff, image_height_in;
   logic [SUM_W-1:0]       keep_sum_ff, keep_sum_in;
   logic [SUM_W-1:0]       fill_sum_ff, fill_sum_in;
   logic [COUNT_W-1:0]     fill_count_ff, fill_count_in;
   logic                   csr_write;
   logic [2:0]             csr_index;
   logic                   size_restart;
   size_cfg_type           size_cfg;
   limit_cfg_type          limit_cfg;
   entry_type              entry, head;
   logic                   entry_push, queue_pop;
   logic [QUEUE_PTR_W:0]   queue_level;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      keep_sum_in     = keep_sum_ff;
      fill_sum_in     = fill_sum_ff;
      fill_count_in   = fill_count_ff;
      size_restart    = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               image_width_in = pwdata[SIZE_W-1:0];
               size_restart   = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               image_height_in = pwdata[SIZE_W-1:0];
               size_restart    = 1'b1;
            end
            REG_KEEP_SUM_LIMIT: begin
               keep_sum_in = pwdata[SUM_W-1:0];
            end
            REG_FILL_SUM_LIMIT: begin
               fill_sum_in = pwdata[SUM_W-1:0];
            end
            REG_FILL_COUNT_LIMIT: begin
               fill_count_in = pwdata[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         keep_sum_ff     <= RST_KEEP_SUM_LIMIT;
         fill_sum_ff     <= RST_FILL_SUM_LIMIT;
         fill_count_ff   <= RST_FILL_COUNT_LIMIT;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         keep_sum_ff     <= keep_sum_in;
         fill_sum_ff     <= fill_sum_in;
         fill_count_ff   <= fill_count_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMAGE_WIDTH:      prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT:     prdata = CSR_DATA_W'(image_height_ff);
         REG_KEEP_SUM_LIMIT:   prdata = CSR_DATA_W'(keep_sum_ff);
         REG_FILL_SUM_LIMIT:   prdata = CSR_DATA_W'(fill_sum_ff);
         REG_FILL_COUNT_LIMIT: prdata = CSR_DATA_W'(fill_count_ff);
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      size_cfg.image_width        = image_width_ff;
      size_cfg.image_height       = image_height_ff;
      size_cfg.restart            = size_restart;
      limit_cfg.keep_sum_limit    = keep_sum_ff;
      limit_cfg.fill_sum_limit    = fill_sum_ff;
      limit_cfg.fill_count_limit  = fill_count_ff;
   end

   nsf_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .size_cfg    (size_cfg),
      .push        (push),
      .full        (full),
      .pixel_value (req_pixel_value),
      .queue_level (queue_level),
      .entry_push  (entry_push),
      .entry       (entry)
   );

   nsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_push),
      .push_entry (entry),
      .pop        (queue_pop),
      .head       (head),
      .level      (queue_level)
   );

   nsf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .limit_cfg          (limit_cfg),
      .head               (head),
      .queue_level        (queue_level),
      .queue_pop          (queue_pop),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_column     (rsp_out_column),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_last_of_input  (rsp_last_of_input)
   );

endmodule

### hw/rtl/nsf_checker.sv
// nsf_checker: port-level assertions for the neighborhood smoothing filter.
// Bound to neighborhood_smoothing_filter; depends on nsf_pkg for the pixel levels.

module nsf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            full,
   input logic                            empty,
   input logic                            pop,
   input logic [7:0]                      rsp_out_row,
   input logic [7:0]                      rsp_out_column,
   input logic [1:0]                      rsp_smoothed_value,
   input logic                            rsp_last_of_input,
   input logic                            psel,
   input logic                            penable,
   input logic                            pready
);
   import nsf_pkg::*;

   // nothing pending and room for input right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("filter not idle after reset");

   // results are only white or full black
   a_two_levels: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_smoothed_value == PIX_WHITE || rsp_smoothed_value == PIX_BLACK))
      else $error("smoothed value neither white nor black");

   // a waiting result holds until taken
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_row) && $stable(rsp_out_column) &&
                            $stable(rsp_smoothed_value) && $stable(rsp_last_of_input)))
      else $error("waiting result changed before pop");

   // config port never inserts wait states
   a_no_wait: assert property (@(posedge clock) disable iff (reset)
      (psel && penable) |-> pready)
      else $error("configuration access stalled");

endmodule

bind neighborhood_smoothing_filter nsf_checker u_nsf_checker (.*);
